// File: rtl/assert_macros.svh
// Assertion macros included by the RTL file that carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge of clk, ignored while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, also active while reset is asserted.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lpht_pkg.sv
// Package with the shared types and constants of the linear probing hash table.
package lpht_pkg;

    localparam int KEY_W      = 31;
    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int SLOT_W     = 4;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_DONE
    } lpht_state_t;

endpackage

// File: rtl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/lpht_mod.sv
// Three-stage unit that reduces a key modulo the table size by reciprocal multiplication.
module lpht_mod import lpht_pkg::*; #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [KEY_W-1:0]              key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] rem
);

    localparam int AW    = $clog2(TABLE_SIZE);
    localparam int SHIFT = KEY_W + AW;
    localparam int Q_W   = KEY_W + 32 - SHIFT;
    // Rounded-up reciprocal; exact quotients for every key below 2^KEY_W.
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TABLE_SIZE - 1)) / 64'(TABLE_SIZE);
    localparam logic [31:0] RECIP   = RECIP_FULL[31:0];
    localparam logic [AW:0] MODULUS = (AW+1)'(TABLE_SIZE);

    logic                  mul_valid_reg;
    logic                  quot_valid_reg;
    logic                  done_reg;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [Q_W-1:0]        quot_reg, quot_next;
    logic [AW-1:0]         rem_reg, rem_next;
    logic [KEY_W+31:0]     prod;
    logic [Q_W+AW:0]       back;

    // Stage one holds the key, stage two the quotient, stage three the remainder.
    assign prod      = {32'b0, key_reg} * {{KEY_W{1'b0}}, RECIP};
    assign back      = {{(AW+1){1'b0}}, quot_reg} * {{Q_W{1'b0}}, MODULUS};
    assign key_next  = start ? key : key_reg;
    assign quot_next = prod[KEY_W+31:SHIFT];
    // The remainder is below the table size, so the low bits of the difference suffice.
    assign rem_next  = key_reg[AW-1:0] - back[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg  <= 1'b0;
            quot_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            mul_valid_reg  <= start;
            quot_valid_reg <= mul_valid_reg;
            done_reg       <= quot_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/linear_probe_hash_table_core.sv
// Linear probing hash table: open-addressed key store with insert, remove and search.
//
// Each input transaction carries an operation in s_tuser (insert, remove or search) and a
// 31-bit key in s_tdata; each one produces exactly one result transaction carrying a status
// in m_tuser and a slot number in m_tdata. The home slot is the key modulo TABLE_SIZE,
// computed by a remainder unit. The probe then reads one slot of the table RAM per cycle,
// walking forward with wrap-around until it meets an empty slot or returns home, so it
// visits 1 to TABLE_SIZE slots; the single read port of the table RAM sets the probe rate.
// Insert fills the first empty slot or reports the table full; remove empties every
// matching slot along the probe run and reports the first one; search reports the first
// match. The unused operation code reports not found. The block takes a new item while a
// finished result still waits in the output register. After reset a clearing pass marks
// every slot empty; s_tready stays low meanwhile.
module linear_probe_hash_table_core import lpht_pkg::*; #(
    parameter int TABLE_SIZE = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [30:0] key, [31] zero
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [3:0] slot, [7:4] zero
    output logic [STAT_W-1:0]    m_tuser    // [1:0] status
);

`include "assert_macros.svh"

    localparam int AW     = $clog2(TABLE_SIZE);
    localparam int ENTRY_W = KEY_W + 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SIZE - 1);

    // Control state.
    lpht_state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          m_valid_reg, m_valid_next;

    // Item and result payload.
    logic [OP_W-1:0]   op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [AW-1:0]     home_reg, home_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic              hit_reg, hit_next;
    logic [AW-1:0]     first_reg, first_next;
    logic [STAT_W-1:0] res_stat_reg, res_stat_next;
    logic [AW-1:0]     res_slot_reg, res_slot_next;
    logic [STAT_W-1:0] m_stat_reg, m_stat_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;

    // Table RAM: each entry is {valid, key}.
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic          mod_start;
    logic          mod_done;
    logic [AW-1:0] mod_rem;

    logic              in_fire;
    logic              rd_valid;
    logic [KEY_W-1:0]  rd_key;
    logic              rd_match;
    logic [AW-1:0]     probe_next;
    logic              probe_wrap;

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    lpht_mod #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (s_tdata[KEY_W-1:0]),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign mod_start = in_fire;

    assign rd_valid   = ram_rdata[KEY_W];
    assign rd_key     = ram_rdata[KEY_W-1:0];
    assign rd_match   = rd_valid && (rd_key == key_reg);
    assign probe_next = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
    assign probe_wrap = (probe_next == home_reg);

    // Main sequencer. In S_PROBE the RAM output holds the entry at slot_reg, read in the
    // previous cycle; the read of the following slot is issued in the same cycle.
    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        home_next     = home_reg;
        slot_next     = slot_reg;
        hit_next      = hit_reg;
        first_next    = first_reg;
        res_stat_next = res_stat_reg;
        res_slot_next = res_slot_reg;
        m_stat_next   = m_stat_reg;
        m_slot_next   = m_slot_reg;
        ram_we        = 1'b0;
        ram_waddr     = slot_reg;
        ram_wdata     = {1'b1, key_reg};
        ram_raddr     = probe_next;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[KEY_W-1:0];
                    hit_next   = 1'b0;
                    first_next = '0;
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                ram_raddr = mod_rem;
                if (mod_done)
                begin
                    home_next  = mod_rem;
                    slot_next  = mod_rem;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                slot_next = probe_next;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (!rd_valid)
                        begin
                            ram_we        = 1'b1;
                            ram_wdata     = {1'b1, key_reg};
                            res_stat_next = STAT_OK;
                            res_slot_next = slot_reg;
                            state_next    = S_DONE;
                        end
                        else if (probe_wrap)
                        begin
                            res_stat_next = STAT_FULL;
                            res_slot_next = '0;
                            state_next    = S_DONE;
                        end
                    end

                    OP_REMOVE:
                    begin
                        if (!rd_valid)
                        begin
                            res_stat_next = hit_reg ? STAT_OK : STAT_MISS;
                            res_slot_next = hit_reg ? first_reg : '0;
                            state_next    = S_DONE;
                        end
                        else
                        begin
                            if (rd_match)
                            begin
                                // Empty this slot; the key bits left behind are dead.
                                ram_we    = 1'b1;
                                ram_wdata = {1'b0, key_reg};
                                hit_next  = 1'b1;
                                if (!hit_reg)
                                begin
                                    first_next = slot_reg;
                                end
                            end
                            if (probe_wrap)
                            begin
                                res_stat_next = (hit_reg || rd_match) ? STAT_OK : STAT_MISS;
                                res_slot_next = hit_reg ? first_reg
                                              : (rd_match ? slot_reg : '0);
                                state_next    = S_DONE;
                            end
                        end
                    end

                    OP_SEARCH:
                    begin
                        if (rd_match)
                        begin
                            res_stat_next = STAT_OK;
                            res_slot_next = slot_reg;
                            state_next    = S_DONE;
                        end
                        else if (!rd_valid || probe_wrap)
                        begin
                            res_stat_next = STAT_MISS;
                            res_slot_next = '0;
                            state_next    = S_DONE;
                        end
                    end

                    default:
                    begin
                        res_stat_next = STAT_MISS;
                        res_slot_next = '0;
                        state_next    = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                // Move the result into the output register once it is free.
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_stat_next  = res_stat_reg;
                    m_slot_next  = SLOT_W'({{SLOT_W{1'b0}}, res_slot_reg});
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        home_reg     <= home_next;
        slot_reg     <= slot_next;
        hit_reg      <= hit_next;
        first_reg    <= first_next;
        res_stat_reg <= res_stat_next;
        res_slot_reg <= res_slot_next;
        m_stat_reg   <= m_stat_next;
        m_slot_reg   <= m_slot_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_stat_reg;
    assign m_tdata  = M_TDATA_W'(m_slot_reg);

    // An accepted transaction always starts the home slot computation.
    `ASSERT_CLK(a_accept_to_hash, (s_tvalid && s_tready) |=> (state_reg == S_HASH),
        "accepted transaction did not enter the hash step")

    // Misses and full reports carry slot zero.
    `ASSERT_CLK(a_miss_slot_zero, (m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata == '0),
        "non-OK result with nonzero slot")

    // The table RAM is written only by the clearing pass or by a probe.
    `ASSERT_CLK(a_write_source, ram_we |-> ((state_reg == S_CLEAR) || (state_reg == S_PROBE)),
        "table write outside clearing pass or probe")

    // A finished result waits while the output register is still occupied.
    `ASSERT_CLK(a_done_holds,
        ((state_reg == S_DONE) && m_tvalid && !m_tready) |=> (state_reg == S_DONE),
        "result left the done state while output was stalled")

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the linear probing hash table core.
`timescale 1ns / 100ps

module tb_top;
    import lpht_pkg::*;

    localparam int TABLE_SIZE = 16;
    localparam int RANDOM_ITEMS = 750;
    localparam int KEY_POOL_SIZE = 24;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;
    localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
    // Operation code three is unused by the block; it must report not found.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // One operation presented on the input stream.
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } table_op_t;

    // One predicted result, with the operation that caused it for reporting.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
    } table_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STAT_W-1:0]    m_tuser;

    // Operations still to be sent, and results owed by the block in order.
    table_op_t     pending_ops[$];
    table_result_t owed_results[$];

    // Shadow copy of the table contents.
    logic [KEY_W-1:0] shadow_key[TABLE_SIZE];
    logic             shadow_used[TABLE_SIZE];

    logic [KEY_W-1:0] key_pool[KEY_POOL_SIZE];

    table_op_t     current_op;
    table_result_t got_result;
    int            tx_gap = 0;
    int            rx_stall = 0;
    bit            tx_calm = 1'b0;
    bit            rx_calm = 1'b0;
    int            error_count = 0;

    linear_probe_hash_table_core #(
        .TABLE_SIZE(TABLE_SIZE)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one operation to the shadow table and returns the result the block must give.
    function automatic table_result_t apply_to_shadow(input table_op_t req);
        table_result_t res;
        int            slot_idx;
        int            n;
        bit            stop;
        bit            hit;

        res.op     = req.op;
        res.key    = req.key;
        res.status = STAT_MISS;
        res.slot   = '0;
        slot_idx   = int'(req.key % TABLE_SIZE);
        stop       = 1'b0;
        hit        = 1'b0;
        case (req.op)
            OP_INSERT:
            begin
                // A full table is left alone; otherwise the first empty slot of the run is taken.
                res.status = STAT_FULL;
                for (n = 0; n < TABLE_SIZE; n++)
                begin
                    if (!stop && !shadow_used[slot_idx])
                    begin
                        shadow_key[slot_idx]  = req.key;
                        shadow_used[slot_idx] = 1'b1;
                        res.status = STAT_OK;
                        res.slot   = slot_idx[SLOT_W-1:0];
                        stop       = 1'b1;
                    end
                    slot_idx = (slot_idx + 1) % TABLE_SIZE;
                end
            end
            OP_REMOVE:
            begin
                // Every copy along the run is emptied; the first one is reported.
                for (n = 0; n < TABLE_SIZE; n++)
                begin
                    if (!stop)
                    begin
                        if (!shadow_used[slot_idx])
                            stop = 1'b1;
                        else if (shadow_key[slot_idx] == req.key)
                        begin
                            shadow_used[slot_idx] = 1'b0;
                            if (!hit)
                            begin
                                hit        = 1'b1;
                                res.status = STAT_OK;
                                res.slot   = slot_idx[SLOT_W-1:0];
                            end
                        end
                    end
                    slot_idx = (slot_idx + 1) % TABLE_SIZE;
                end
            end
            OP_SEARCH:
            begin
                for (n = 0; n < TABLE_SIZE; n++)
                begin
                    if (!stop)
                    begin
                        if (!shadow_used[slot_idx])
                            stop = 1'b1;
                        else if (shadow_key[slot_idx] == req.key)
                        begin
                            res.status = STAT_OK;
                            res.slot   = slot_idx[SLOT_W-1:0];
                            stop       = 1'b1;
                        end
                    end
                    slot_idx = (slot_idx + 1) % TABLE_SIZE;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Idle length: mostly none, sometimes short, rarely a long stretch.
    function automatic int pick_idle();
        int r;

        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_op(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
        table_op_t req;

        req.op  = op;
        req.key = key;
        pending_ops.push_back(req);
    endtask

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Input driver. A transaction is accepted at an edge where s_tvalid and s_tready are
    // both high; the shadow table is updated right then, so the prediction follows the
    // exact order in which the block sees the operations.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                owed_results.push_back(apply_to_shadow(current_op));
                if ($urandom_range(0, 79) == 0)
                    tx_calm = !tx_calm;
            end
            if (!s_tvalid || s_tready)
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_ops.size() != 0)
                begin
                    current_op = pending_ops.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(current_op.key);
                    s_tuser  <= current_op.op;
                    tx_gap = tx_calm ? 0 : pick_idle();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor and back-pressure. Each accepted result transaction is compared
    // with the oldest prediction, field by field.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (owed_results.size() == 0)
                    log_error($sformatf("result with none owed: status %0d slot %0d",
                                        m_tuser, m_tdata[SLOT_W-1:0]));
                else
                begin
                    got_result = owed_results.pop_front();
                    if (m_tuser !== got_result.status ||
                        m_tdata[SLOT_W-1:0] !== got_result.slot)
                        log_error($sformatf(
                            "op %0d key 0x%08h: expected status %0d slot %0d, got status %0d slot %0d",
                            got_result.op, got_result.key, got_result.status, got_result.slot,
                            m_tuser, m_tdata[SLOT_W-1:0]));
                end
            end
            if ($urandom_range(0, 299) == 0)
                rx_calm = !rx_calm;
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 5) == 0)
                    rx_stall = pick_idle();
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        int i;
        int r;
        int phase;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;

        for (i = 0; i < TABLE_SIZE; i++)
        begin
            shadow_key[i]  = '0;
            shadow_used[i] = 1'b0;
        end

        // Two keys in three are clustered on home slots 0 to 3 or 13 to 15, so that probe runs
        // wrap around; the rest have random home slots, and all upper bits stay random.
        for (i = 0; i < KEY_POOL_SIZE; i++)
        begin
            key = KEY_W'($urandom);
            case (i % 3)
                0: key[3:0] = 4'($urandom_range(0, 3));
                1: key[3:0] = 4'($urandom_range(13, 15));
                default: key[3:0] = 4'($urandom);
            endcase
            key_pool[i] = key;
        end

        // Directed part: misses on the empty table, the unused code, the widest key,
        // wrap-around from the last slot, a duplicate insert and a remove of both copies.
        queue_op(OP_SEARCH, KEY_W'(5));
        queue_op(OP_REMOVE, KEY_W'(5));
        queue_op(OP_UNUSED, KEY_MAX);
        queue_op(OP_INSERT, KEY_MAX);
        queue_op(OP_INSERT, KEY_W'(15));
        queue_op(OP_INSERT, KEY_W'(15));
        queue_op(OP_SEARCH, KEY_W'(15));
        queue_op(OP_REMOVE, KEY_W'(15));
        queue_op(OP_SEARCH, KEY_W'(15));
        queue_op(OP_SEARCH, KEY_MAX);
        // Fill the table, then insert into the full table and search it end to end.
        for (i = 0; i < TABLE_SIZE - 1; i++)
            queue_op(OP_INSERT, key_pool[i]);
        queue_op(OP_INSERT, '0);
        queue_op(OP_SEARCH, KEY_W'(19));

        // Random part: phases lean toward removes, balance, or inserts so the table
        // moves between nearly empty and full; most keys come from the pool.
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            phase = (i / 50) % 3;
            r = $urandom_range(0, 99);
            if (r < 5)
                op = OP_UNUSED;
            else if (r < (phase == 0 ? 25 : (phase == 1 ? 45 : 65)))
                op = OP_INSERT;
            else if (r < 78)
                op = (phase == 0) ? OP_REMOVE : OP_SEARCH;
            else
                op = (phase == 0) ? OP_SEARCH : OP_REMOVE;
            r = $urandom_range(0, 99);
            if (r < 3)
                key = '0;
            else if (r < 6)
                key = KEY_MAX;
            else if (r < 14)
                key = KEY_W'($urandom);
            else
                key = key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
            queue_op(op, key);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || s_tvalid)
            @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (owed_results.size() != 0)
            log_error($sformatf("%0d results never arrived", owed_results.size()));
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every probe full length.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
